// File: hdl/slcf_pkg.sv
// ----------------------------------------------------------------------------
// slcf_pkg
// Shared types and constants for the stereo low-pass cascade filter: sample
// and state widths, register indexes, sequencer states, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package slcf_pkg;

   // Sample is Q1.15, section state is Q2.22
   localparam int SAMPLE_W = 16;
   localparam int STATE_W  = 24;
   localparam int SCALE_SH = STATE_W - SAMPLE_W - 1;   // 7 fraction bits added

   // Five sections per channel: two in the first cascade, three in the second
   localparam int NUM_SECT = 5;
   localparam int SECT_W   = 3;
   localparam int NUM_CH   = 2;

   typedef logic [SECT_W-1:0] sect_idx_type;

   localparam sect_idx_type SECT_FIRST  = 3'd0;
   localparam sect_idx_type SECT_SECOND = 3'd1;
   localparam sect_idx_type SECT_LED0   = 3'd2;
   localparam sect_idx_type SECT_LED2   = 3'd4;

   // Register map
   localparam int CSR_IDX_W = 3;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_BOARD_MODEL  = 3'd0;
   localparam csr_idx_type REG_FORCE_FILTER = 3'd1;
   localparam csr_idx_type REG_LED_ACTIVE   = 3'd2;
   localparam csr_idx_type REG_COEF_FIRST   = 3'd3;
   localparam csr_idx_type REG_COEF_SECOND  = 3'd4;
   localparam csr_idx_type REG_COEF_LED     = 3'd5;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;    // capture the input sample pair
      logic         mul;     // start one section multiply
      logic         ch;      // 0 left, 1 right
      sect_idx_type idx;     // section being computed
      logic         emit;    // round, saturate and present the result
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic first_on;        // first cascade enabled
      logic led_on;          // second cascade enabled
      logic out_busy;        // result register still held by the sink
   } dp_status_type;

endpackage

// File: hdl/slcf_ctrl.sv
// ----------------------------------------------------------------------------
// slcf_ctrl
// Sequencer for the filter. Walks the enabled sections in order, issuing the
// left and right multiply of each section on consecutive cycles, then drains
// the last update and hands the result to the output register.
// ----------------------------------------------------------------------------
module slcf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  slcf_pkg::dp_status_type status,
   output slcf_pkg::dp_cmd_type   cmd
);
   import slcf_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   sect_idx_type idx_ff;
   sect_idx_type idx_in;
   logic         has_next;
   sect_idx_type idx_next;

   // Next enabled section after the current one
   always_comb begin
      has_next = 1'b1;
      idx_next = idx_ff + sect_idx_type'(1);
      if (idx_ff == SECT_SECOND) begin
         has_next = status.led_on;
      end else if (idx_ff == SECT_LED2) begin
         has_next = 1'b0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.first_on) begin
                  state_in = ST_MUL_L;
                  idx_in   = SECT_FIRST;
               end else if (status.led_on) begin
                  state_in = ST_MUL_L;
                  idx_in   = SECT_LED0;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_MUL_L: begin
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            if (has_next) begin
               state_in = ST_MUL_L;
               idx_in   = idx_next;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.mul   = (state_ff == ST_MUL_L) || (state_ff == ST_MUL_R);
      cmd.ch    = (state_ff == ST_MUL_R);
      cmd.idx   = idx_ff;
      cmd.emit  = (state_ff == ST_EMIT) && !status.out_busy;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= SECT_FIRST;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: hdl/slcf_dp.sv
// ----------------------------------------------------------------------------
// slcf_dp
// Datapath: configuration registers, ten section states, one shared
// multiplier with a registered product, the section update, and the
// rounding/saturating output register.
// ----------------------------------------------------------------------------
module slcf_dp #(
   parameter int COEF_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  slcf_pkg::csr_idx_type           csr_index,
   input  logic [COEF_BITS-1:0]            csr_wdata,
   // input samples
   input  logic signed [slcf_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [slcf_pkg::SAMPLE_W-1:0] req_sample_right,
   // results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_left,
   output logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_right,
   // controller
   input  slcf_pkg::dp_cmd_type            cmd,
   output slcf_pkg::dp_status_type         status
);
   import slcf_pkg::*;

   localparam int DIFF_W = STATE_W + 1;
   localparam int PROD_W = DIFF_W + COEF_BITS + 1;
   localparam int CORR_W = STATE_W + 2;
   localparam int RND_W  = STATE_W + 1;
   localparam int RES_W  = RND_W - SCALE_SH;
   localparam logic [PROD_W-1:0] HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (COEF_BITS - 1);
   localparam logic [COEF_BITS-1:0] COEF_RST = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(32768);

   // Configuration registers
   logic                 board_model_ff;
   logic                 force_filter_ff;
   logic                 led_active_ff;
   logic [COEF_BITS-1:0] coef_first_ff;
   logic [COEF_BITS-1:0] coef_second_ff;
   logic [COEF_BITS-1:0] coef_led_ff;

   // Section states and running cascade value per channel
   logic signed [STATE_W-1:0] sect_ff [NUM_CH][NUM_SECT];
   logic signed [STATE_W-1:0] cur_ff  [NUM_CH];

   // Multiply stage
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [STATE_W-1:0] y_ff;
   logic                      upd_ff;
   logic                      upd_ch_ff;
   sect_idx_type              upd_idx_ff;

   logic signed [STATE_W-1:0] x_sel;
   logic signed [STATE_W-1:0] y_sel;
   logic signed [DIFF_W-1:0]  diff;
   logic [COEF_BITS-1:0]      coef_sel;
   logic signed [COEF_BITS:0] coef_s;

   // Update stage
   logic signed [PROD_W-1:0]  acc;
   logic signed [PROD_W-1:0]  acc_sh;
   logic signed [CORR_W-1:0]  ysum;
   logic signed [STATE_W-1:0] ynew;

   // Output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] out_l_ff;
   logic signed [SAMPLE_W-1:0] out_r_ff;
   logic signed [SAMPLE_W-1:0] out_l_in;
   logic signed [SAMPLE_W-1:0] out_r_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_model_ff  <= 1'b0;
         force_filter_ff <= 1'b0;
         led_active_ff   <= 1'b0;
         coef_first_ff   <= COEF_RST;
         coef_second_ff  <= COEF_RST;
         coef_led_ff     <= COEF_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BOARD_MODEL:  board_model_ff  <= csr_wdata[0];
            REG_FORCE_FILTER: force_filter_ff <= csr_wdata[0];
            REG_LED_ACTIVE:   led_active_ff   <= csr_wdata[0];
            REG_COEF_FIRST:   coef_first_ff   <= csr_wdata;
            REG_COEF_SECOND:  coef_second_ff  <= csr_wdata;
            REG_COEF_LED:     coef_led_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign status.first_on = !board_model_ff;
   assign status.led_on   = force_filter_ff || led_active_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // Operand select and difference x - y
   always_comb begin
      x_sel = cur_ff[cmd.ch];
      y_sel = sect_ff[cmd.ch][cmd.idx];
      diff  = DIFF_W'(x_sel) - DIFF_W'(y_sel);
      if (cmd.idx == SECT_FIRST) begin
         coef_sel = coef_first_ff;
      end else if (cmd.idx == SECT_SECOND) begin
         coef_sel = coef_second_ff;
      end else begin
         coef_sel = coef_led_ff;
      end
      coef_s  = $signed({1'b0, coef_sel});
      prod_in = diff * coef_s;
   end

   // Product register and update tag
   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      y_ff       <= y_sel;
      upd_ch_ff  <= cmd.ch;
      upd_idx_ff <= cmd.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff <= 1'b0;
      end else begin
         upd_ff <= cmd.mul;
      end
   end

   // y + floor((a*(x-y) + half) / 2^COEF_BITS)
   always_comb begin
      acc    = prod_ff + $signed(HALF);
      acc_sh = acc >>> COEF_BITS;
      ysum   = CORR_W'(y_ff) + acc_sh[CORR_W-1:0];
      ynew   = ysum[STATE_W-1:0];
   end

   // Section state and cascade value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            for (int s = 0; s < NUM_SECT; s++) begin
               sect_ff[c][s] <= '0;
            end
         end
      end else if (upd_ff) begin
         sect_ff[upd_ch_ff][upd_idx_ff] <= ynew;
      end
   end

   // Samples widened to Q2.22 with sign extension
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff[0] <= STATE_W'(req_sample_left)  <<< SCALE_SH;
         cur_ff[1] <= STATE_W'(req_sample_right) <<< SCALE_SH;
      end else if (upd_ff) begin
         cur_ff[upd_ch_ff] <= ynew;
      end
   end

   // Round Q2.22 to Q1.15 and saturate
   function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [STATE_W-1:0] y);
      logic signed [RND_W-1:0] t;
      logic signed [RES_W-1:0] r;
      t = RND_W'(y) + RND_W'(64);
      r = t[RND_W-1:SCALE_SH];
      if (r > OUT_MAX) begin
         return OUT_MAX[SAMPLE_W-1:0];
      end else if (r < OUT_MIN) begin
         return OUT_MIN[SAMPLE_W-1:0];
      end
      return r[SAMPLE_W-1:0];
   endfunction

   assign out_l_in = to_out(cur_ff[0]);
   assign out_r_in = to_out(cur_ff[1]);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_l_ff <= out_l_in;
         out_r_ff <= out_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;

endmodule

// File: hdl/stereo_lowpass_cascade_filter_top.sv
// One item at a time: a new input beat is taken only after the previous result has been
// handed to the output register. The single shared multiplier does one section of one
// channel per cycle, left and right interleaved.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high) clears all ten section states, the flags, and
// sets the three coefficients to one half.
// ----------------------------------------------------------------------------
// stereo_lowpass_cascade_filter_top
// Stereo fixed-point one-pole low-pass cascade: an optional two-section
// cascade followed by an optional three-section cascade, saturated to Q1.15.
// ----------------------------------------------------------------------------
module stereo_lowpass_cascade_filter_top #(
   parameter int COEF_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  slcf_pkg::csr_idx_type                csr_index,
   input  logic [COEF_BITS-1:0]                 csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [slcf_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [slcf_pkg::SAMPLE_W-1:0] req_sample_right,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_left,
   output logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_right
);
   import slcf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   slcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   slcf_dp #(
      .COEF_BITS (COEF_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: hdl/slcf_checker.sv
// ----------------------------------------------------------------------------
// slcf_checker
// Port-level checks for the filter top level, attached by bind.
// ----------------------------------------------------------------------------
module slcf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_ready,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_left,
   input logic signed [slcf_pkg::SAMPLE_W-1:0] rsp_out_right
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_left)
                                 && $stable(rsp_out_right))
      else $error("result beat changed while stalled");

   // One item at a time: the block is busy right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the item finished");

   // No result appears the cycle after a beat is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result raised too early");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Configuration port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind stereo_lowpass_cascade_filter_top slcf_checker u_slcf_checker (.*);

// File: tb/sv/slcf_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slcf_scoreboard_pkg
// Scoreboard for the stereo low-pass cascade filter: keeps its own copy of
// the registers and the ten section states, computes the filtered pair for
// every accepted input beat, and compares result beats in order.
// ----------------------------------------------------------------------------
package slcf_scoreboard_pkg;

   import slcf_pkg::*;

   localparam int COEF_W    = 16;
   localparam int COEF_HALF = 1 << (COEF_W - 1);

   typedef logic signed [SAMPLE_W-1:0] q15_type;
   typedef logic signed [STATE_W-1:0]  q22_type;
   typedef logic [COEF_W-1:0]          coef_type;

   typedef struct {
      q15_type left;
      q15_type right;
   } stereo_pair_type;

   class lowpass_scoreboard;

      bit              board_model;
      bit              force_filter;
      bit              led_active;
      coef_type        coef_first;
      coef_type        coef_second;
      coef_type        coef_led;
      q22_type         sect_state [NUM_CH][NUM_SECT];
      stereo_pair_type expected_pairs [$];
      int              errors;

      function new();
         int c;
         int s;
         board_model  = 1'b0;
         force_filter = 1'b0;
         led_active   = 1'b0;
         coef_first   = coef_type'(COEF_HALF);
         coef_second  = coef_type'(COEF_HALF);
         coef_led     = coef_type'(COEF_HALF);
         errors       = 0;
         for (c = 0; c < NUM_CH; c++)
            for (s = 0; s < NUM_SECT; s++)
               sect_state[c][s] = '0;
      endfunction

      // register write, value masked to the register width
      function void apply_write(csr_idx_type idx, coef_type data);
         case (idx)
            REG_BOARD_MODEL:  board_model  = data[0];
            REG_FORCE_FILTER: force_filter = data[0];
            REG_LED_ACTIVE:   led_active   = data[0];
            REG_COEF_FIRST:   coef_first   = data;
            REG_COEF_SECOND:  coef_second  = data;
            REG_COEF_LED:     coef_led     = data;
            default: ;
         endcase
      endfunction

      // y + floor((a*(x - y) + half) / 2^COEF_W)
      function q22_type lp_section(q22_type y, q22_type x, coef_type a);
         longint diff;
         longint prod;
         diff = longint'(x) - longint'(y);
         prod = diff * longint'(a) + COEF_HALF;
         return q22_type'(longint'(y) + (prod >>> COEF_W));
      endfunction

      // Q2.22 to Q1.15, round half up, saturate
      function q15_type round_sat(q22_type y);
         longint r;
         r = (longint'(y) + 64) >>> SCALE_SH;
         if (r > 32767)
            r = 32767;
         if (r < -32768)
            r = -32768;
         return q15_type'(r);
      endfunction

      function q15_type filter_channel(int ch, q15_type din);
         q22_type x;
         int      s;
         x = q22_type'(din) <<< SCALE_SH;
         if (!board_model) begin
            sect_state[ch][0] = lp_section(sect_state[ch][0], x, coef_first);
            sect_state[ch][1] = lp_section(sect_state[ch][1], sect_state[ch][0], coef_second);
            x = sect_state[ch][1];
         end
         if (force_filter || led_active) begin
            sect_state[ch][2] = lp_section(sect_state[ch][2], x, coef_led);
            for (s = 3; s < NUM_SECT; s++)
               sect_state[ch][s] = lp_section(sect_state[ch][s], sect_state[ch][s-1], coef_led);
            x = sect_state[ch][NUM_SECT-1];
         end
         return round_sat(x);
      endfunction

      // accepted input beat: predict the filtered pair
      function void note_input(q15_type left, q15_type right);
         stereo_pair_type p;
         p.left  = filter_channel(0, left);
         p.right = filter_channel(1, right);
         expected_pairs.push_back(p);
      endfunction

      // accepted result beat: compare against the oldest prediction
      function void check_result(q15_type left, q15_type right);
         stereo_pair_type p;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected result beat left %0d right %0d", $time, left, right);
            errors++;
            return;
         end
         p = expected_pairs.pop_front();
         if (left !== p.left) begin
            $display("%0t: out_left expected %0d actual %0d", $time, p.left, left);
            errors++;
         end
         if (right !== p.right) begin
            $display("%0t: out_right expected %0d actual %0d", $time, p.right, right);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction

   endclass

endpackage

// File: tb/sv/stereo_lowpass_cascade_filter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_lowpass_cascade_filter_top_tb
// Drives stereo sample beats through the cascade filter under several
// register settings and idle/stall mixes, and checks every result beat
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module stereo_lowpass_cascade_filter_top_tb;

   import slcf_pkg::*;
   import slcf_scoreboard_pkg::*;

   localparam int          SETTLE_CYCLES = 16;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam int          PHASE_ITEMS   = 40;
   localparam int          PHASES        = 7;
   localparam csr_idx_type REG_SPARE_LO  = 3'd6;    // unmapped indexes
   localparam csr_idx_type REG_SPARE_HI  = 3'd7;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index        = REG_BOARD_MODEL;
   coef_type    csr_wdata        = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   q15_type     req_sample_left  = '0;
   q15_type     req_sample_right = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   q15_type     rsp_out_left;
   q15_type     rsp_out_right;

   lowpass_scoreboard sb;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                cycle_count    = 0;

   stereo_lowpass_cascade_filter_top #(.COEF_BITS(COEF_W)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_left, rsp_out_right);
   end

   // one register write beat; csr_valid stays high until csr_done
   task automatic csr_write(csr_idx_type idx, coef_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.apply_write(idx, data);
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   // one sample beat, with an optional gap in front
   task automatic send_pair(q15_type left, q15_type right);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_left  <= left;
      req_sample_right <= right;
      do @(posedge clock); while (req_stall);
      sb.note_input(left, right);
   endtask

   task automatic burst_done();
      req_valid <= 1'b0;
   endtask

   // hold off until every predicted pair has come back
   task automatic wait_drained();
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // flag value in bit 0, noise above it to exercise masking
   function automatic coef_type flag_word(bit flag);
      return coef_type'(($urandom & 16'hFFFE) | flag);
   endfunction

   function automatic coef_type pick_coef();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return coef_type'(1);
         3:       return coef_type'(COEF_HALF);
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic q15_type pick_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return q15_type'($urandom_range(511)) - 16'sd256;
         default: return q15_type'($urandom);
      endcase
   endfunction

   // new random setting, then a run of random beats
   task automatic random_phase();
      int n;
      wait_drained();
      csr_write(REG_BOARD_MODEL,  flag_word($urandom_range(1)));
      csr_write(REG_FORCE_FILTER, flag_word($urandom_range(3) == 0));
      csr_write(REG_LED_ACTIVE,   flag_word($urandom_range(1)));
      csr_write(REG_COEF_FIRST,   pick_coef());
      csr_write(REG_COEF_SECOND,  pick_coef());
      csr_write(REG_COEF_LED,     pick_coef());
      if ($urandom_range(3) == 0)
         csr_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, coef_type'($urandom));
      csr_done();
      for (n = 0; n < PHASE_ITEMS; n++)
         send_pair(pick_sample(), pick_sample());
      burst_done();
   endtask

   initial begin
      int r;
      int p;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset setting: first cascade only, coefficients one half
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      send_pair(16'sh0000, 16'sh0000);
      send_pair(-16'sd1, 16'sd1);
      burst_done();

      // both cascades off: straight pass-through
      wait_drained();
      csr_write(REG_BOARD_MODEL, coef_type'(1));
      csr_write(REG_FORCE_FILTER, '0);
      csr_write(REG_LED_ACTIVE, '0);
      csr_done();
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      send_pair(16'sh5555, -16'sh5556);
      burst_done();

      // writes to unmapped indexes are ignored; LED cascade alone at max coef
      wait_drained();
      csr_write(REG_SPARE_LO, '1);
      csr_write(REG_SPARE_HI, '1);
      csr_write(REG_LED_ACTIVE, coef_type'(1));
      csr_write(REG_COEF_LED, '1);
      csr_done();
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      burst_done();

      // both cascades forced on, zero and full coefficients
      wait_drained();
      csr_write(REG_BOARD_MODEL, '0);
      csr_write(REG_FORCE_FILTER, coef_type'(1));
      csr_write(REG_LED_ACTIVE, '0);
      csr_write(REG_COEF_FIRST, '0);
      csr_write(REG_COEF_SECOND, '1);
      csr_write(REG_COEF_LED, '0);
      csr_done();
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh1234, -16'sh1234);
      burst_done();

      // smallest first coefficient, largest second and LED coefficients, both flags set
      wait_drained();
      csr_write(REG_COEF_FIRST, coef_type'(1));
      csr_write(REG_COEF_SECOND, '1);
      csr_write(REG_COEF_LED, '1);
      csr_write(REG_LED_ACTIVE, coef_type'(1));
      csr_done();
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      send_pair(16'sh0001, -16'sd1);
      send_pair(16'sh7FFF, 16'sh7FFF);
      burst_done();

      // random part: receiver-heavy stall, sender-heavy idle, then none
      for (r = 0; r < 3; r++) begin
         send_idle_pct  = (r == 0) ? 30 : (r == 1) ? 80 : 0;
         recv_stall_pct = (r == 0) ? 80 : (r == 1) ? 30 : 0;
         for (p = 0; p < PHASES; p++)
            random_phase();
      end

      wait_drained();
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
